// ----- design/smf_pkg.sv -----
// Shared types and constants for the sliding median filter.
// No dependencies; used by smf_cell, smf_chain and sliding_median_filter_core.
package smf_pkg;

   localparam int MAX_WINDOW_DEF  = 32;
   localparam int SAMPLE_BITS_DEF = 16;
   localparam int CSR_BITS        = 6;

   localparam logic [CSR_BITS-1:0] WINDOW_LENGTH_RESET = CSR_BITS'(5);

   typedef enum logic [1:0] {
      SMF_IDLE   = 2'd0,
      SMF_UPDATE = 2'd1,
      SMF_SELECT = 2'd2
   } smf_state_type;

   // flags a cell hands to its neighbor
   typedef struct packed {
      logic valid;
      logic above;  // key is greater than the incoming key
   } smf_link_type;

   // broadcast to every cell
   typedef struct packed {
      logic update;
      logic clear;
      logic remove; // window full: drop the cell holding the oldest key
   } smf_cell_ctrl_type;

endpackage

// ----- design/smf_cell.sv -----
// One cell of the sorted sample chain: holds a value and its ring slot.
// Depends on smf_pkg.
module smf_cell #(
   parameter int VALUE_W = smf_pkg::SAMPLE_BITS_DEF,
   parameter int SLOT_W  = 5
) (
   input  logic                          clock,
   input  logic                          reset,
   input  smf_pkg::smf_cell_ctrl_type    ctrl,
   input  logic signed [VALUE_W-1:0]     new_value,
   input  logic        [SLOT_W-1:0]      new_slot,
   input  logic signed [VALUE_W-1:0]     old_value,
   // raw contents of the cell above
   input  logic signed [VALUE_W-1:0]     up_value,
   input  logic        [SLOT_W-1:0]      up_slot,
   input  smf_pkg::smf_link_type         up_link,
   // cell below, after removal
   input  logic signed [VALUE_W-1:0]     dn_value,
   input  logic        [SLOT_W-1:0]      dn_slot,
   input  smf_pkg::smf_link_type         dn_link,
   // own raw contents, to the cell below
   output logic signed [VALUE_W-1:0]     raw_value,
   output logic        [SLOT_W-1:0]      raw_slot,
   output smf_pkg::smf_link_type         raw_link,
   // own entry after removal, to the cell above
   output logic signed [VALUE_W-1:0]     del_value,
   output logic        [SLOT_W-1:0]      del_slot,
   output smf_pkg::smf_link_type         del_link
);

   logic signed [VALUE_W-1:0] value_ff, value_in;
   logic        [SLOT_W-1:0]  slot_ff, slot_in;
   logic                      valid_ff, valid_in;
   logic                      above_new;
   logic                      at_or_above_old;
   logic                      ins_here;

   // keys are (value, slot): unique, so ties never occur
   always_comb begin
      above_new = valid_ff &&
         ((value_ff > new_value) || ((value_ff == new_value) && (slot_ff > new_slot)));
      at_or_above_old = ctrl.remove && valid_ff &&
         ((value_ff > old_value) || ((value_ff == old_value) && (slot_ff >= new_slot)));
   end

   assign raw_value      = value_ff;
   assign raw_slot       = slot_ff;
   assign raw_link.valid = valid_ff;
   assign raw_link.above = above_new;

   // removal closes the gap by pulling the upper neighbor down
   assign del_value = at_or_above_old ? up_value : value_ff;
   assign del_slot  = at_or_above_old ? up_slot  : slot_ff;
   assign del_link  = at_or_above_old ? up_link  : raw_link;

   always_comb begin
      ins_here = dn_link.valid && !dn_link.above && (!del_link.valid || del_link.above);
      valid_in = dn_link.above || ins_here || del_link.valid;
      if (dn_link.above) begin
         value_in = dn_value;
         slot_in  = dn_slot;
      end else if (ins_here) begin
         value_in = new_value;
         slot_in  = new_slot;
      end else begin
         value_in = del_value;
         slot_in  = del_slot;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || ctrl.clear) begin
         valid_ff <= 1'b0;
      end else if (ctrl.update) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.update) begin
         value_ff <= value_in;
         slot_ff  <= slot_in;
      end
   end

endmodule

// ----- design/smf_chain.sv -----
// Row of smf_cell instances kept sorted ascending, valid entries packed low.
// Depends on smf_pkg and smf_cell.
module smf_chain #(
   parameter int MAX_WINDOW = smf_pkg::MAX_WINDOW_DEF,
   parameter int VALUE_W    = smf_pkg::SAMPLE_BITS_DEF,
   parameter int SLOT_W     = 5
) (
   input  logic                          clock,
   input  logic                          reset,
   input  smf_pkg::smf_cell_ctrl_type    ctrl,
   input  logic signed [VALUE_W-1:0]     new_value,
   input  logic        [SLOT_W-1:0]      new_slot,
   input  logic signed [VALUE_W-1:0]     old_value,
   output logic signed [VALUE_W-1:0]     cell_value [MAX_WINDOW],
   output logic        [MAX_WINDOW-1:0]  cell_valid
);

   logic signed [VALUE_W-1:0] raw_value [MAX_WINDOW+1];
   logic        [SLOT_W-1:0]  raw_slot  [MAX_WINDOW+1];
   smf_pkg::smf_link_type     raw_link  [MAX_WINDOW+1];
   logic signed [VALUE_W-1:0] del_value [MAX_WINDOW+1];
   logic        [SLOT_W-1:0]  del_slot  [MAX_WINDOW+1];
   smf_pkg::smf_link_type     del_link  [MAX_WINDOW+1];

   // raw index MAX_WINDOW is the empty slot above the top cell
   assign raw_value[MAX_WINDOW]       = '0;
   assign raw_slot[MAX_WINDOW]        = '0;
   assign raw_link[MAX_WINDOW].valid  = 1'b0;
   assign raw_link[MAX_WINDOW].above  = 1'b0;

   // del index 0 stands for the floor below cell 0: always lets insertion through
   assign del_value[0]       = '0;
   assign del_slot[0]        = '0;
   assign del_link[0].valid  = 1'b1;
   assign del_link[0].above  = 1'b0;

   for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
      smf_cell #(
         .VALUE_W (VALUE_W),
         .SLOT_W  (SLOT_W)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (ctrl),
         .new_value (new_value),
         .new_slot  (new_slot),
         .old_value (old_value),
         .up_value  (raw_value[i+1]),
         .up_slot   (raw_slot[i+1]),
         .up_link   (raw_link[i+1]),
         .dn_value  (del_value[i]),
         .dn_slot   (del_slot[i]),
         .dn_link   (del_link[i]),
         .raw_value (raw_value[i]),
         .raw_slot  (raw_slot[i]),
         .raw_link  (raw_link[i]),
         .del_value (del_value[i+1]),
         .del_slot  (del_slot[i+1]),
         .del_link  (del_link[i+1])
      );
      assign cell_value[i] = raw_value[i];
      assign cell_valid[i] = raw_link[i].valid;
   end

endmodule

// ----- design/sliding_median_filter_core.sv -----
// Sliding-window median filter, top level.
// Depends on smf_pkg and smf_chain (which instantiates smf_cell).
//
// Each req item carries one signed sample; each rsp item returns the median of
// the most recent samples and a full flag. The effective window is the
// csr_wr_data register rounded up to odd and clamped to MAX_WINDOW; any write
// restarts the filter from an empty window. While filling, the median is the
// element at position count/2 of the sorted samples (upper median for an even
// count). An item passes through accept (ring read of the oldest sample),
// chain update (every cell moves by one place at most), and median select
// into the output register. The next item is accepted while a result still
// waits in the output register. No clearing pass after reset.

module sliding_median_filter_core #(
   parameter int MAX_WINDOW  = smf_pkg::MAX_WINDOW_DEF,
   parameter int SAMPLE_BITS = smf_pkg::SAMPLE_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // sample channel
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic signed [SAMPLE_BITS-1:0]     req_sample,
   // result channel
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [SAMPLE_BITS-1:0]     rsp_median,
   output logic                              rsp_window_full,
   // window length register
   input  logic                              csr_wr_en,
   input  logic [smf_pkg::CSR_BITS-1:0]      csr_wr_data
);

   localparam int SLOT_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
   localparam int CMP_W  = (smf_pkg::CSR_BITS > CNT_W) ? smf_pkg::CSR_BITS + 1 : CNT_W + 1;

   smf_pkg::smf_state_type state_ff, state_in;

   logic [smf_pkg::CSR_BITS-1:0]  window_length_ff;
   logic [SLOT_W-1:0]             wp_ff, wp_in;
   logic [CNT_W-1:0]              fill_ff, fill_in;
   logic signed [SAMPLE_BITS-1:0] sample_ff;
   logic signed [SAMPLE_BITS-1:0] oldest_ff;
   logic signed [SAMPLE_BITS-1:0] ring_mem [MAX_WINDOW];

   logic                          rsp_valid_ff;
   logic signed [SAMPLE_BITS-1:0] rsp_median_ff;
   logic                          rsp_full_ff;

   logic [CMP_W-1:0]              odd_len;
   logic [CNT_W-1:0]              win;
   logic                          full_now;
   logic [CNT_W-1:0]              wp_next_ext;
   logic [SLOT_W-1:0]             mid_idx;

   logic                          accept;
   logic                          update_en;
   logic                          rsp_load;

   smf_pkg::smf_cell_ctrl_type    cell_ctrl;
   logic signed [SAMPLE_BITS-1:0] cell_value [MAX_WINDOW];
   logic [MAX_WINDOW-1:0]         cell_valid;

   // effective window: round even up to odd, clamp to MAX_WINDOW
   always_comb begin
      odd_len = CMP_W'(window_length_ff | smf_pkg::CSR_BITS'(1));
      if (odd_len > CMP_W'(MAX_WINDOW)) begin
         win = CNT_W'(MAX_WINDOW);
      end else begin
         win = CNT_W'(odd_len);
      end
   end

   assign full_now = (fill_ff == win);

   // ring pointer and fill count after this item
   always_comb begin
      wp_next_ext = CNT_W'(wp_ff) + CNT_W'(1);
      wp_in       = (wp_next_ext == win) ? '0 : SLOT_W'(wp_next_ext);
      fill_in     = full_now ? fill_ff : fill_ff + CNT_W'(1);
      mid_idx     = SLOT_W'(fill_ff >> 1);
   end

   // ---------------- control ----------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         smf_pkg::SMF_IDLE:   if (req_valid) state_in = smf_pkg::SMF_UPDATE;
         smf_pkg::SMF_UPDATE: state_in = smf_pkg::SMF_SELECT;
         smf_pkg::SMF_SELECT: if (!rsp_valid_ff || !rsp_stall) state_in = smf_pkg::SMF_IDLE;
         default:             state_in = smf_pkg::SMF_IDLE;
      endcase
   end

   always_comb begin
      req_stall = 1'b1;
      update_en = 1'b0;
      rsp_load  = 1'b0;
      unique case (state_ff)
         smf_pkg::SMF_IDLE:   req_stall = 1'b0;
         smf_pkg::SMF_UPDATE: update_en = 1'b1;
         smf_pkg::SMF_SELECT: rsp_load  = !rsp_valid_ff || !rsp_stall;
         default:             req_stall = 1'b1;
      endcase
   end

   assign accept = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= smf_pkg::SMF_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // ---------------- config and counters ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         window_length_ff <= smf_pkg::WINDOW_LENGTH_RESET;
         wp_ff            <= '0;
         fill_ff          <= '0;
      end else if (csr_wr_en) begin
         // any write restarts from an empty window
         window_length_ff <= csr_wr_data;
         wp_ff            <= '0;
         fill_ff          <= '0;
      end else if (update_en) begin
         wp_ff            <= wp_in;
         fill_ff          <= fill_in;
      end
   end

   // ---------------- sample ring ----------------
   // read port follows wp_ff; at accept it yields the sample about to be evicted
   always_ff @(posedge clock) begin
      oldest_ff <= ring_mem[wp_ff];
      if (update_en) begin
         ring_mem[wp_ff] <= sample_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         sample_ff <= req_sample;
      end
   end

   // ---------------- sorted chain ----------------
   assign cell_ctrl.update = update_en;
   assign cell_ctrl.clear  = csr_wr_en;
   assign cell_ctrl.remove = full_now;

   smf_chain #(
      .MAX_WINDOW (MAX_WINDOW),
      .VALUE_W    (SAMPLE_BITS),
      .SLOT_W     (SLOT_W)
   ) u_chain (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (cell_ctrl),
      .new_value  (sample_ff),
      .new_slot   (wp_ff),
      .old_value  (oldest_ff),
      .cell_value (cell_value),
      .cell_valid (cell_valid)
   );

   // ---------------- output register ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_median_ff <= cell_value[mid_idx];
         rsp_full_ff   <= full_now;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_median      = rsp_median_ff;
   assign rsp_window_full = rsp_full_ff;

   // ---------------- assertions ----------------
   a_fill_in_window: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= win)
      else $error("fill count beyond window");

   a_wp_in_window: assert property (@(posedge clock) disable iff (reset)
      CNT_W'(wp_ff) < win)
      else $error("write position beyond window");

   a_chain_count: assert property (@(posedge clock) disable iff (reset)
      $countones(cell_valid) == fill_ff)
      else $error("chain occupancy differs from fill count");

   a_chain_packed: assert property (@(posedge clock) disable iff (reset)
      ((cell_valid + MAX_WINDOW'(1)) & cell_valid) == '0)
      else $error("chain valid entries not packed");

endmodule
